// File: rtl/clock_calendar_counter_unit_assert.svh
// Assertion macros for the clock and calendar unit.
// Every use samples on clk and is disabled while rst is high.
`ifndef CLOCK_CALENDAR_COUNTER_UNIT_ASSERT_SVH
`define CLOCK_CALENDAR_COUNTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define CCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define CCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CCC_ASSERT(lbl, prop, msg)

`define CCC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/ccc_pkg.sv
package ccc_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic FMT_24H = 1'b0;
  localparam logic FMT_12H = 1'b1;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 80;

  localparam logic [5:0]  MAX_SEC     = 6'd59;
  localparam logic [5:0]  MAX_MIN     = 6'd59;
  localparam logic [4:0]  MAX_HOUR_24 = 5'd23;
  localparam logic [4:0]  NOON_HOUR   = 5'd12;
  localparam logic [13:0] MAX_YEAR    = 14'd9999;

  localparam logic [13:0] RESET_YEAR    = 14'd2022;
  localparam logic [6:0]  RESET_YEAR_HI = 7'd20;
  localparam logic [6:0]  RESET_YEAR_LO = 7'd22;
  localparam logic [6:0]  LAST_YEAR_LO  = 7'd99;

  // reciprocal of 100 scaled by 2^19, exact for 14-bit values
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SH  = 19;

  typedef struct packed {
    logic       op;
    logic [4:0] hour;
    logic [5:0] minute;
  } item_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/clock_calendar_counter_unit.sv
// Real-time clock and calendar.
// Input stream: s_tuser selects the operation (0 one-second tick, 1 set
// time), s_tdata carries a decimal HHMM value for a set word. Every input
// word produces exactly one output word on m_* with the full time and date
// after that word, plus the wrapping tick count.
// Config channel: cfg_data selects the hour format (0 24-hour, 1 12-hour
// with pm flag); cfg_ready is always high. Write it only while idle.
// Path: decode register, then calendar registers, then m_tdata.
// Throughput: one word per cycle while m_tready is high; the decode register
// feeds the calendar update, which is combinational.
// Reset: 00:00:00, 1 January 2022, 24-hour mode, tick count 0.
// Receiver stall: the result holds on m_tdata; the decode register takes at
// most one more word, then s_tready stays low until m_tready returns.
module clock_calendar_counter_unit import ccc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [13:0] time_value
  input  logic                 s_tuser,  // [0] operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [5:0] seconds, [11:6] minutes, [16:12] hours, [17] pm, [22:18] day,
  // [26:23] month, [40:27] year, [72:41] tick_count, rest zero
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  logic        fmt;
  logic        advance;
  logic        itm_valid;
  item_t       itm;
  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hour;
  logic        pm;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [31:0] ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_24H;
    end else if (cfg_valid) begin
      fmt <= cfg_data;
    end
  end

  ccc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .advance   (advance),
    .itm_valid (itm_valid),
    .itm       (itm)
  );

  ccc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fmt       (fmt),
    .itm_valid (itm_valid),
    .itm       (itm),
    .advance   (advance),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sec       (sec),
    .min       (min),
    .hour      (hour),
    .pm        (pm),
    .day       (day),
    .month     (month),
    .year      (year),
    .ticks     (ticks)
  );

  assign m_tdata = {7'd0, ticks, year, month, day, (fmt == FMT_12H) && pm, hour, min, sec};

endmodule

// File: rtl/ccc_decode.sv
module ccc_decode import ccc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [13:0] time_value
  input  logic                 s_tuser,  // [0] operation
  input  logic                 advance,
  output logic                 itm_valid,
  output item_t                itm
);

  logic [13:0] tv;
  logic [26:0] prod;
  logic [7:0]  quo;
  logic [13:0] quo100;
  logic [13:0] rem;
  item_t       itm_next;

  assign tv     = s_tdata[13:0];
  assign prod   = 27'(tv) * 27'(RECIP_100);
  assign quo    = prod[RECIP_SH +: 8];
  assign quo100 = (14'(quo) << 6) + (14'(quo) << 5) + (14'(quo) << 2);
  assign rem    = tv - quo100;

  always_comb begin
    itm_next.op     = s_tuser;
    itm_next.hour   = (quo > 8'(MAX_HOUR_24)) ? MAX_HOUR_24 : quo[4:0];
    itm_next.minute = (rem > 14'(MAX_MIN)) ? MAX_MIN : rem[5:0];
  end

  assign s_tready = !itm_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      itm_valid <= 1'b0;
    end else if (s_tready) begin
      itm_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      itm <= itm_next;
    end
  end

endmodule

// File: rtl/ccc_core.sv
`include "clock_calendar_counter_unit_assert.svh"

module ccc_core import ccc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fmt,
  input  logic        itm_valid,
  input  item_t       itm,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  sec,
  output logic [5:0]  min,
  output logic [4:0]  hour,
  output logic        pm,
  output logic [4:0]  day,
  output logic [3:0]  month,
  output logic [13:0] year,
  output logic [31:0] ticks
);

  logic [6:0]  year_hi;
  logic [6:0]  year_lo;
  logic [5:0]  sec_next;
  logic [5:0]  min_next;
  logic [4:0]  hour_next;
  logic        pm_next;
  logic [4:0]  day_next;
  logic [3:0]  month_next;
  logic [13:0] year_next;
  logic [6:0]  year_hi_next;
  logic [6:0]  year_lo_next;
  logic [31:0] ticks_next;
  logic        midnight;
  logic        leap;
  logic [5:0]  day_inc;
  logic        step;

  assign advance = !out_valid || out_ready;
  assign step    = itm_valid && advance;
  assign leap    = (year_lo != 7'd0) ? (year_lo[1:0] == 2'd0) : (year_hi[1:0] == 2'd0);
  assign day_inc = 6'(day) + 6'd1;

  always_comb begin
    sec_next     = sec;
    min_next     = min;
    hour_next    = hour;
    pm_next      = pm;
    day_next     = day;
    month_next   = month;
    year_next    = year;
    year_hi_next = year_hi;
    year_lo_next = year_lo;
    ticks_next   = ticks;
    midnight     = 1'b0;
    if (itm.op == OP_SET) begin
      hour_next = itm.hour;
      min_next  = itm.minute;
      sec_next  = 6'd0;
    end else begin
      ticks_next = ticks + 32'd1;
      if (sec >= MAX_SEC) begin
        sec_next = 6'd0;
        if (min >= MAX_MIN) begin
          min_next = 6'd0;
          if (fmt == FMT_12H) begin
            if (hour >= NOON_HOUR) begin
              hour_next = 5'd1;
            end else begin
              hour_next = hour + 5'd1;
              if (hour_next == NOON_HOUR) begin
                pm_next  = !pm;
                midnight = pm;
              end
            end
          end else begin
            if (hour >= MAX_HOUR_24) begin
              hour_next = 5'd0;
              midnight  = 1'b1;
            end else begin
              hour_next = hour + 5'd1;
            end
          end
        end else begin
          min_next = min + 6'd1;
        end
      end else begin
        sec_next = sec + 6'd1;
      end
      if (midnight) begin
        if (day_inc > 6'(month_days(month, leap))) begin
          day_next = 5'd1;
          if (month >= 4'd12) begin
            month_next = 4'd1;
            if (year < MAX_YEAR) begin
              year_next = year + 14'd1;
              if (year_lo == LAST_YEAR_LO) begin
                year_lo_next = 7'd0;
                year_hi_next = year_hi + 7'd1;
              end else begin
                year_lo_next = year_lo + 7'd1;
              end
            end
          end else begin
            month_next = month + 4'd1;
          end
        end else begin
          day_next = day_inc[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec       <= 6'd0;
      min       <= 6'd0;
      hour      <= 5'd0;
      pm        <= 1'b0;
      day       <= 5'd1;
      month     <= 4'd1;
      year      <= RESET_YEAR;
      year_hi   <= RESET_YEAR_HI;
      year_lo   <= RESET_YEAR_LO;
      ticks     <= 32'd0;
    end else begin
      if (advance) begin
        out_valid <= itm_valid;
      end
      if (step) begin
        sec     <= sec_next;
        min     <= min_next;
        hour    <= hour_next;
        pm      <= pm_next;
        day     <= day_next;
        month   <= month_next;
        year    <= year_next;
        year_hi <= year_hi_next;
        year_lo <= year_lo_next;
        ticks   <= ticks_next;
      end
    end
  end

  `CCC_ASSERT(a_time_range, (sec <= MAX_SEC) && (min <= MAX_MIN), "time out of range")
  `CCC_ASSERT(a_date_range, (day != 5'd0) && (month != 4'd0) && (month <= 4'd12),
              "date out of range")
  `CCC_ASSERT(a_year_split, (year == 14'(year_hi) * 14'd100 + 14'(year_lo)) && (year <= MAX_YEAR),
              "year split counters disagree")
  `CCC_ASSERT_NEXT(a_tick_count, step && (itm.op == OP_TICK), ticks == $past(ticks) + 32'd1,
                   "tick count did not advance")
  `CCC_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(ticks) &&
                   $stable(sec) && $stable(day), "result changed while stalled")

endmodule
